### rtl/rfr_pkg.sv
// rfr_pkg: shared constants, types and codes of the ranging frame receiver
// no dependencies
`default_nettype none

package rfr_pkg;

  // sync pair and frame geometry
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam int unsigned FRAME_BYTES = 21;

  localparam int unsigned POS_W = 5;
  typedef logic [POS_W-1:0] pos_t;

  // byte positions inside a frame
  localparam pos_t POS_FIRST_DATA = pos_t'(2);
  localparam pos_t POS_SEQ        = pos_t'(4);
  localparam pos_t POS_TAG_LO     = pos_t'(5);
  localparam pos_t POS_TAG_HI     = pos_t'(6);
  localparam pos_t POS_STN_LO     = pos_t'(7);
  localparam pos_t POS_STN_HI     = pos_t'(8);
  localparam pos_t POS_DIST_0     = pos_t'(9);
  localparam pos_t POS_DIST_1     = pos_t'(10);
  localparam pos_t POS_DIST_2     = pos_t'(11);
  localparam pos_t POS_DIST_3     = pos_t'(12);
  localparam pos_t POS_BATT       = pos_t'(13);
  localparam pos_t POS_LAST_SUM   = pos_t'(FRAME_BYTES - 3);
  localparam pos_t POS_CSUM_LO    = pos_t'(FRAME_BYTES - 2);

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SUM = 1'b1;

  // sync hunting phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_SAW55 = 3'b010,
    PH_FRAME = 3'b100
  } phase_t;

  // one decoded result
  typedef struct packed {
    logic               status;
    logic [7:0]         sequence_res;
    logic signed [15:0] tag_id;
    logic signed [15:0] station_id;
    logic signed [31:0] distance_cm;
    logic [7:0]         battery;
  } result_t;

endpackage : rfr_pkg

`default_nettype wire

### rtl/rfr_parser.sv
// rfr_parser: sync hunt, frame collection and checksum check, one byte per step
// depends on rfr_pkg
`default_nettype none

module rfr_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  output logic                 emit,
  output rfr_pkg::result_t     result
);
  import rfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  pos_t        pos_r, pos_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  csum_lo_r, csum_lo_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] stn_r, stn_nxt;
  logic [31:0] dist_r, dist_nxt;
  logic [7:0]  batt_r, batt_nxt;
  logic        sum_ok;

  // received checksum against inverted running sum
  assign sum_ok = (~sum_r == {rx_byte, csum_lo_r});

  // next state for one byte
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    sum_nxt     = sum_r;
    csum_lo_nxt = csum_lo_r;
    seq_nxt     = seq_r;
    tag_nxt     = tag_r;
    stn_nxt     = stn_r;
    dist_nxt    = dist_r;
    batt_nxt    = batt_r;
    emit        = 1'b0;
    unique case (phase_r)
      PH_SAW55: begin
        if (rx_byte == SYNC_SECOND) begin
          phase_nxt = PH_FRAME;
          pos_nxt   = POS_FIRST_DATA;
          sum_nxt   = '0;
        end else if (rx_byte == SYNC_FIRST) begin
          phase_nxt = PH_SAW55;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_FRAME: begin
        if (pos_r >= POS_FIRST_DATA && pos_r <= POS_LAST_SUM) begin
          sum_nxt = sum_r + {8'd0, rx_byte};
          pos_nxt = pos_r + pos_t'(1);
          if (pos_r == POS_SEQ)    seq_nxt          = rx_byte;
          if (pos_r == POS_TAG_LO) tag_nxt[7:0]     = rx_byte;
          if (pos_r == POS_TAG_HI) tag_nxt[15:8]    = rx_byte;
          if (pos_r == POS_STN_LO) stn_nxt[7:0]     = rx_byte;
          if (pos_r == POS_STN_HI) stn_nxt[15:8]    = rx_byte;
          if (pos_r == POS_DIST_0) dist_nxt[7:0]    = rx_byte;
          if (pos_r == POS_DIST_1) dist_nxt[15:8]   = rx_byte;
          if (pos_r == POS_DIST_2) dist_nxt[23:16]  = rx_byte;
          if (pos_r == POS_DIST_3) dist_nxt[31:24]  = rx_byte;
          if (pos_r == POS_BATT)   batt_nxt         = rx_byte;
        end else if (pos_r == POS_CSUM_LO) begin
          csum_lo_nxt = rx_byte;
          pos_nxt     = pos_r + pos_t'(1);
        end else begin
          // final checksum byte: report and go back to hunting
          emit      = 1'b1;
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
          sum_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = (rx_byte == SYNC_FIRST) ? PH_SAW55 : PH_HUNT;
      end
    endcase
  end

  // result fields, zeroed on a checksum mismatch
  always_comb begin
    if (sum_ok) begin
      result.status       = STATUS_OK;
      result.sequence_res = seq_r;
      result.tag_id       = tag_r;
      result.station_id   = stn_r;
      result.distance_cm  = dist_r;
      result.battery      = batt_r;
    end else begin
      result              = '0;
      result.status       = STATUS_BAD_SUM;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      sum_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // frame payload holds
  always_ff @(posedge clk) begin
    if (step) begin
      csum_lo_r <= csum_lo_nxt;
      seq_r     <= seq_nxt;
      tag_r     <= tag_nxt;
      stn_r     <= stn_nxt;
      dist_r    <= dist_nxt;
      batt_r    <= batt_nxt;
    end
  end

endmodule : rfr_parser

`default_nettype wire

### rtl/ranging_frame_receiver.sv
// ranging_frame_receiver: top level with input register, parser and result register
// depends on rfr_pkg and rfr_parser
//
// Usage:
//   in_valid/in_ready/in_rx_byte carries one received serial byte per request.
//   The block hunts for the sync pair 0x55 0xAA (sliding match), collects a
//   21-byte frame and checks the inverted 16-bit sum of bytes 2..18 against
//   the little-endian checksum in bytes 19 and 20.
//   out_valid/out_ready carries one result request per frame: out_status 0
//   with sequence, tag, station, distance and battery, or out_status 1 with
//   all other fields zero when the checksum does not match.
//   A byte is registered at acceptance, then parsed from the input register,
//   and the result register loads as the final byte is parsed, so a result
//   request shows once its final byte has passed both registers.
//   Throughput: one byte per cycle unless a result stall holds it; the parser
//   step uses compares and one 16-bit add between input and state registers.
//   Stall: when out_ready is low with a result pending, the input register
//   holds its byte and in_ready drops once it is occupied.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to hunting for sync with no partial frame.
`default_nettype none

module ranging_frame_receiver (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_status,
  output logic [7:0]              out_sequence_res,
  output logic signed [15:0]      out_tag_id,
  output logic signed [15:0]      out_station_id,
  output logic signed [31:0]      out_distance_cm,
  output logic [7:0]              out_battery
);
  import rfr_pkg::*;

  logic        byte_vld_r;
  logic [7:0]  byte_r;
  logic        out_vld_r;
  result_t     res_r;
  logic        out_free;
  logic        step;
  logic        emit;
  result_t     result;

  // handshake
  assign out_free = !out_vld_r || out_ready;
  assign step     = byte_vld_r && out_free;
  assign in_ready = !byte_vld_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_vld_r <= 1'b1;
    end else if (step) begin
      byte_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  // frame parser
  rfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (byte_r),
    .emit    (emit),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_r <= result;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = res_r.status;
  assign out_sequence_res = res_r.sequence_res;
  assign out_tag_id       = res_r.tag_id;
  assign out_station_id   = res_r.station_id;
  assign out_distance_cm  = res_r.distance_cm;
  assign out_battery      = res_r.battery;

endmodule : ranging_frame_receiver

`default_nettype wire

### bench/tb_ranging_frame_receiver.sv
// tb_ranging_frame_receiver: self-checking bench for the ranging frame receiver
// drives serial bytes through a decoder of its own and compares every result request
// depends on rfr_pkg and ranging_frame_receiver
`default_nettype none

module tb_ranging_frame_receiver;
  import rfr_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned FRAMES_PER_PHASE = 7;

  localparam result_t NO_RESULT = '0;
  localparam result_t BAD_SUM_RESULT = result_t'({STATUS_BAD_SUM, 80'h0});
  localparam result_t ALL_ONES_RESULT = result_t'({STATUS_OK, {80{1'b1}}});

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } byte_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic out_status;
  logic [7:0] out_sequence_res;
  logic signed [15:0] out_tag_id;
  logic signed [15:0] out_station_id;
  logic signed [31:0] out_distance_cm;
  logic [7:0] out_battery;

  ranging_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_sequence_res (out_sequence_res),
    .out_tag_id       (out_tag_id),
    .out_station_id   (out_station_id),
    .out_distance_cm  (out_distance_cm),
    .out_battery      (out_battery)
  );

  // decoder state mirrored from the block
  phase_t      hunt_phase;
  pos_t        frame_pos;
  logic [15:0] sum_acc;
  logic [7:0]  csum_lo_acc;
  logic [7:0]  seq_acc;
  logic [15:0] tag_acc;
  logic [15:0] station_acc;
  logic [31:0] distance_acc;
  logic [7:0]  battery_acc;

  result_t pending_frames[$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // directed bytes: sliding sync, sync bytes as data, bad checksum,
  // then a good frame of all ones with every field at its extreme
  byte_row_t directed_rows [45] = '{
    '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h55, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT}, '{8'h10, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'h00, 1'b1, BAD_SUM_RESULT},
    '{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, NO_RESULT}, '{8'h10, 1'b0, NO_RESULT}, '{8'hEF, 1'b1, ALL_ONES_RESULT}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_frame_acc();
    frame_pos = '0;
    sum_acc = '0;
    csum_lo_acc = '0;
    seq_acc = '0;
    tag_acc = '0;
    station_acc = '0;
    distance_acc = '0;
    battery_acc = '0;
  endfunction

  // one byte through the frame decoder; returns 1 when the byte closes a frame
  function automatic bit decode_rx_byte(input logic [7:0] b, output result_t res);
    res = NO_RESULT;
    case (hunt_phase)
      PH_SAW55: begin
        if (b == SYNC_SECOND) begin
          clear_frame_acc();
          hunt_phase = PH_FRAME;
          frame_pos = POS_FIRST_DATA;
        end else if (b != SYNC_FIRST) begin
          hunt_phase = PH_HUNT;
        end
        return 1'b0;
      end
      PH_FRAME: ;
      default: begin
        if (b == SYNC_FIRST) hunt_phase = PH_SAW55;
        else hunt_phase = PH_HUNT;
        return 1'b0;
      end
    endcase

    // summed payload bytes
    if (frame_pos >= POS_FIRST_DATA && frame_pos <= POS_LAST_SUM) begin
      sum_acc = sum_acc + 16'(b);
      case (frame_pos)
        POS_SEQ:    seq_acc = b;
        POS_TAG_LO: tag_acc[7:0] = b;
        POS_TAG_HI: tag_acc[15:8] = b;
        POS_STN_LO: station_acc[7:0] = b;
        POS_STN_HI: station_acc[15:8] = b;
        POS_DIST_0: distance_acc[7:0] = b;
        POS_DIST_1: distance_acc[15:8] = b;
        POS_DIST_2: distance_acc[23:16] = b;
        POS_DIST_3: distance_acc[31:24] = b;
        POS_BATT:   battery_acc = b;
        default: ;
      endcase
      frame_pos = frame_pos + pos_t'(1);
      return 1'b0;
    end
    if (frame_pos == POS_CSUM_LO) begin
      csum_lo_acc = b;
      frame_pos = frame_pos + pos_t'(1);
      return 1'b0;
    end

    // final byte closes the frame
    if (~sum_acc == {b, csum_lo_acc})
      res = result_t'({STATUS_OK, seq_acc, tag_acc, station_acc, distance_acc, battery_acc});
    else
      res = BAD_SUM_RESULT;
    hunt_phase = PH_HUNT;
    clear_frame_acc();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] error: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // offer one byte request, hold it until taken, then predict
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
    result_t predicted;
    bit closes;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    closes = decode_rx_byte(b, predicted);
    if (typed) pending_frames.insert(pending_frames.size(), want);
    else if (closes) pending_frames.insert(pending_frames.size(), predicted);
  endtask

  // biased byte: extremes and sync values show up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return SYNC_FIRST;
      3: return SYNC_SECOND;
      4: return 8'h80;
      5: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // a well-formed frame with random content, sometimes damaged or cut short
  task automatic send_frame();
    logic [7:0] body [FRAME_BYTES];
    logic [15:0] sum;
    int cut;
    sum = '0;
    body[0] = SYNC_FIRST;
    body[1] = SYNC_SECOND;
    for (int i = 2; i <= int'(POS_LAST_SUM); i++) begin
      body[i] = pick_byte();
      sum = sum + 16'(body[i]);
    end
    {body[20], body[19]} = ~sum;
    // one frame in five gets a flipped bit
    if ($urandom_range(4) == 0) body[$urandom_range(2, 20)] ^= 8'(1 << $urandom_range(7));
    // one in ten is truncated and runs into the next one
    cut = ($urandom_range(9) == 0) ? $urandom_range(2, 20) : FRAME_BYTES;
    repeat ($urandom_range(3)) send_byte(pick_byte(), 1'b0, NO_RESULT);
    for (int i = 0; i < cut; i++) send_byte(body[i], 1'b0, NO_RESULT);
  endtask

  // stop offering and wait out every expected result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each accepted result request with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result request with nothing expected");
      end else begin
        want = pending_frames.pop_front();
        if (want.status == STATUS_OK) good_frames++;
        else bad_frames++;
        check_field("status", out_status, want.status);
        check_field("sequence_res", out_sequence_res, want.sequence_res);
        check_field("tag_id", out_tag_id, want.tag_id);
        check_field("station_id", out_station_id, want.station_id);
        check_field("distance_cm", out_distance_cm, want.distance_cm);
        check_field("battery", out_battery, want.battery);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_frames.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    hunt_phase = PH_HUNT;
    clear_frame_acc();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
    drain();

    // random frames under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      repeat (FRAMES_PER_PHASE) send_frame();
      drain();
    end

    // long output hold-off with the input kept busy so the block backs up
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_OFF_CYCLES;
    repeat (3) send_frame();
    drain();

    if (pending_frames.size() != 0) report_mismatch("expected results left over");
    $display("sent %0d bytes: %0d good frames and %0d checksum errors checked,", bytes_sent,
             good_frames, bad_frames);
    $display("with sliding sync, truncated frames, idle/stall mixes and a long hold-off");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/rfr_pkg.sv
rtl/rfr_parser.sv
rtl/ranging_frame_receiver.sv
bench/tb_ranging_frame_receiver.sv
